FILE: rtl/core/gmkf_pkg.sv
// ----------------------------------------------------------------------------
// gmkf_pkg: shared types and constants of the greedy knapsack fill
// Action codes, register indexes, port widths, parameter defaults and the
// sequencer state type.
// ----------------------------------------------------------------------------
package gmkf_pkg;

   localparam int MAX_ITEMS_DEF           = 64;
   localparam int MAX_RESOURCES_DEF       = 4;
   localparam int USAGE_FRACTION_BITS_DEF = 24;

   localparam int REQ_DATA_W = 40;    // item_slot, resource_slot, load_value
   localparam int REQ_USER_W = 2;     // action
   localparam int RSP_DATA_W = 104;   // selected_mask, total_profit, padding
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam int PROFIT_W   = 38;
   localparam int MASK_W     = 64;

   typedef enum logic [1:0] {
      ACT_CAPACITY    = 2'd0,
      ACT_CONSUMPTION = 2'd1,
      ACT_PROFIT      = 2'd2,
      ACT_SOLVE       = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ITEMS_IN_USE     = 1'b0,
      REG_RESOURCES_IN_USE = 1'b1
   } csr_reg_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_U_ITEM,
      ST_U_RES,
      ST_U_WAIT,
      ST_U_DIV,
      ST_R_ITEM,
      ST_R_LOADI,
      ST_R_READJ,
      ST_R_CAPJ,
      ST_R_MAL,
      ST_R_MAH,
      ST_R_MBL,
      ST_R_MBH,
      ST_R_CMP,
      ST_F_ITEM,
      ST_F_ORD,
      ST_F_RES,
      ST_F_CHK,
      ST_F_PROF,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/core/gmkf_ram.sv
// ----------------------------------------------------------------------------
// gmkf_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module gmkf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/greedy_multidim_knapsack_fill.sv
// ----------------------------------------------------------------------------
// A load word is accepted one per cycle while the sequencer is idle, and gives
// no result; no request is taken while a solve runs. A solve computes the usages
// with the bit-serial usage divider, ranks the items with the one-multiplier
// rank loop and then walks the items in rank order to fill the knapsack.
// Reset is synchronous: it clears the sequencer, the result valid and the item
// count and sets the resource count to one; the stores hold what was last loaded.
// ----------------------------------------------------------------------------
// greedy_multidim_knapsack_fill: greedy fill of a multidimensional knapsack
// Loads capacities, consumptions and profits, then ranks items by density
// and selects each item that still fits every capacity.
// ----------------------------------------------------------------------------
module greedy_multidim_knapsack_fill #(
   parameter int MAX_ITEMS           = gmkf_pkg::MAX_ITEMS_DEF,
   parameter int MAX_RESOURCES       = gmkf_pkg::MAX_RESOURCES_DEF,
   parameter int USAGE_FRACTION_BITS = gmkf_pkg::USAGE_FRACTION_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [5:0] item_slot, [7:6] resource_slot, [39:8] load_value
   input  logic [gmkf_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] action
   input  logic [gmkf_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [63:0] selected_mask, [101:64] total_profit, [103:102] zero
   output logic [gmkf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [gmkf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gmkf_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // Index and counter widths. Counters hold a count up to the depth itself
   // and index stores through a part-select.
   localparam int IW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW  = $clog2(MAX_ITEMS + 1);
   localparam int RIW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
   localparam int RCW = $clog2(MAX_RESOURCES + 1);
   localparam int CAD = MAX_ITEMS * MAX_RESOURCES;
   localparam int CAW = (CAD > 1) ? $clog2(CAD) : 1;
   // Quotient of one consumption/capacity ratio, the usage sum, the stored
   // usage (saturated at 64 bits) and the density cross-product.
   localparam int QW  = 32 + USAGE_FRACTION_BITS;
   localparam int DCW = $clog2(QW + 1);
   localparam int SW  = QW + RIW;
   localparam int UW  = (SW > 64) ? 64 : SW;
   localparam int PW  = 32 + UW;
   localparam int PAD = gmkf_pkg::RSP_DATA_W - gmkf_pkg::MASK_W - gmkf_pkg::PROFIT_W;

   // Request word fields.
   gmkf_pkg::action_type act_w;
   logic [5:0]  req_item_w;
   logic [1:0]  req_res_w;
   logic [31:0] req_val_w;
   logic        req_fire_w;

   assign act_w      = gmkf_pkg::action_type'(req_tuser);
   assign req_item_w = req_tdata[5:0];
   assign req_res_w  = req_tdata[7:6];
   assign req_val_w  = req_tdata[39:8];
   assign req_fire_w = req_tvalid && req_tready;

   // Sequencer and datapath registers.
   gmkf_pkg::state_type state_ff, state_in;
   logic [6:0]      items_ff;
   logic [2:0]      res_ff;
   logic [31:0]     cap_ff [MAX_RESOURCES];
   logic [CW-1:0]   i_ff;        // item counter of every phase
   logic [CW-1:0]   j_ff;        // opponent counter of the rank phase
   logic [IW-1:0]   cnt_ff;      // rank of the current item
   logic [RCW-1:0]  r_ff;        // resource counter
   logic [SW-1:0]   sum_ff;
   logic [QW-1:0]   dvd_ff;      // dividend shifting out, quotient shifting in
   logic [31:0]     rem_ff;
   logic [DCW-1:0]  dcnt_ff;
   logic [31:0]     pi_ff, pj_ff;
   logic [UW-1:0]   ui_ff, uj_ff;
   logic [63:0]     prod_ff;
   logic [PW-1:0]   acc_a_ff, acc_b_ff;
   logic [IW-1:0]   it_ff;
   logic            fit_ff;
   logic [31:0]     buf_ff [MAX_RESOURCES];
   logic [31:0]     tot_ff [MAX_RESOURCES];
   logic [MAX_ITEMS-1:0] mask_ff;
   logic [gmkf_pkg::PROFIT_W-1:0] psum_ff;
   logic            rsp_valid_ff;
   logic [gmkf_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // Effective item and resource counts.
   logic [CW-1:0]  n_w;
   logic [RCW-1:0] m_w;

   assign n_w = ({1'b0, items_ff} > 8'(MAX_ITEMS)) ? CW'(MAX_ITEMS) : CW'(items_ff);
   assign m_w = ({1'b0, res_ff} > 4'(MAX_RESOURCES)) ? RCW'(MAX_RESOURCES) : RCW'(res_ff);

   // Memory ports.
   logic            cons_we_w;
   logic [CAW-1:0]  cons_wa_w, cons_ra_w;
   logic [31:0]     cons_rd_w;
   logic            prof_we_w;
   logic [IW-1:0]   prof_wa_w, prof_ra_w;
   logic [31:0]     prof_rd_w;
   logic            use_we_w;
   logic [IW-1:0]   use_ra_w;
   logic [UW-1:0]   use_wd_w, use_rd_w;
   logic            ord_we_w;
   logic [IW-1:0]   ord_ra_w;
   logic [IW-1:0]   ord_rd_w;

   gmkf_ram #(.WIDTH(32), .DEPTH(CAD)) u_cons_ram (
      .clock   (clock),
      .wr_en   (cons_we_w),
      .wr_addr (cons_wa_w),
      .wr_data (req_val_w),
      .rd_addr (cons_ra_w),
      .rd_data (cons_rd_w)
   );

   gmkf_ram #(.WIDTH(32), .DEPTH(MAX_ITEMS)) u_prof_ram (
      .clock   (clock),
      .wr_en   (prof_we_w),
      .wr_addr (prof_wa_w),
      .wr_data (req_val_w),
      .rd_addr (prof_ra_w),
      .rd_data (prof_rd_w)
   );

   gmkf_ram #(.WIDTH(UW), .DEPTH(MAX_ITEMS)) u_use_ram (
      .clock   (clock),
      .wr_en   (use_we_w),
      .wr_addr (i_ff[IW-1:0]),
      .wr_data (use_wd_w),
      .rd_addr (use_ra_w),
      .rd_data (use_rd_w)
   );

   gmkf_ram #(.WIDTH(IW), .DEPTH(MAX_ITEMS)) u_ord_ram (
      .clock   (clock),
      .wr_en   (ord_we_w),
      .wr_addr (cnt_ff),
      .wr_data (i_ff[IW-1:0]),
      .rd_addr (ord_ra_w),
      .rd_data (ord_rd_w)
   );

   // Capacity of the resource under the counter.
   logic [31:0] cap_sel_w;
   logic [31:0] tot_sel_w;

   assign cap_sel_w = cap_ff[r_ff[RIW-1:0]];
   assign tot_sel_w = tot_ff[r_ff[RIW-1:0]];

   // Restoring divider step: one quotient bit per cycle.
   logic [32:0]   trial_w;
   logic          ge_w;
   logic [QW-1:0] quot_w;

   assign trial_w = {rem_ff, dvd_ff[QW-1]};
   assign ge_w    = trial_w >= {1'b0, cap_sel_w};
   assign quot_w  = {dvd_ff[QW-2:0], ge_w};

   // Usage written back: saturated to the store width, floored at one unit.
   logic [UW-1:0] use_sat_w;

   assign use_sat_w = (sum_ff > SW'({UW{1'b1}})) ? {UW{1'b1}} : UW'(sum_ff);
   assign use_wd_w  = (use_sat_w == '0) ? UW'(1) : use_sat_w;

   // The single multiplier of the rank loop, one partial product per cycle.
   logic [31:0] mul_a_w, mul_b_w;

   always_comb begin
      mul_a_w = pi_ff;
      mul_b_w = uj_ff[31:0];
      case (state_ff)
         gmkf_pkg::ST_R_MAH: begin
            mul_b_w = 32'(uj_ff[UW-1:32]);
         end
         gmkf_pkg::ST_R_MBL: begin
            mul_a_w = pj_ff;
            mul_b_w = ui_ff[31:0];
         end
         gmkf_pkg::ST_R_MBH: begin
            mul_a_w = pj_ff;
            mul_b_w = 32'(ui_ff[UW-1:32]);
         end
         default: begin
         end
      endcase
   end

   // Item j ranks before item i when profit_j*usage_i beats profit_i*usage_j,
   // or the two are equal and j has the lower index.
   logic [PW-1:0] acc_b_full_w;
   logic          before_w;

   assign acc_b_full_w = acc_b_ff + PW'({prod_ff, 32'b0});
   assign before_w = (acc_b_full_w > acc_a_ff) ||
                     ((acc_b_full_w == acc_a_ff) && (j_ff < i_ff));

   // A consumption that would overrun its capacity.
   logic over_w;

   assign over_w = (33'(tot_sel_w) + 33'(cons_rd_w)) > 33'(cap_sel_w);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gmkf_pkg::ST_IDLE: begin
            if (req_fire_w && act_w == gmkf_pkg::ACT_SOLVE) begin
               state_in = gmkf_pkg::ST_U_ITEM;
            end
         end
         gmkf_pkg::ST_U_ITEM:
            state_in = (i_ff == n_w) ? gmkf_pkg::ST_R_ITEM : gmkf_pkg::ST_U_RES;
         gmkf_pkg::ST_U_RES: begin
            if (r_ff == m_w) begin
               state_in = gmkf_pkg::ST_U_ITEM;
            end else if (cap_sel_w != '0) begin
               state_in = gmkf_pkg::ST_U_WAIT;
            end
         end
         gmkf_pkg::ST_U_WAIT:  state_in = gmkf_pkg::ST_U_DIV;
         gmkf_pkg::ST_U_DIV:
            state_in = (dcnt_ff == DCW'(1)) ? gmkf_pkg::ST_U_RES : gmkf_pkg::ST_U_DIV;
         gmkf_pkg::ST_R_ITEM:
            state_in = (i_ff == n_w) ? gmkf_pkg::ST_F_ITEM : gmkf_pkg::ST_R_LOADI;
         gmkf_pkg::ST_R_LOADI: state_in = gmkf_pkg::ST_R_READJ;
         gmkf_pkg::ST_R_READJ:
            state_in = (j_ff == n_w) ? gmkf_pkg::ST_R_ITEM : gmkf_pkg::ST_R_CAPJ;
         gmkf_pkg::ST_R_CAPJ:  state_in = gmkf_pkg::ST_R_MAL;
         gmkf_pkg::ST_R_MAL:   state_in = gmkf_pkg::ST_R_MAH;
         gmkf_pkg::ST_R_MAH:   state_in = gmkf_pkg::ST_R_MBL;
         gmkf_pkg::ST_R_MBL:   state_in = gmkf_pkg::ST_R_MBH;
         gmkf_pkg::ST_R_MBH:   state_in = gmkf_pkg::ST_R_CMP;
         gmkf_pkg::ST_R_CMP:   state_in = gmkf_pkg::ST_R_READJ;
         gmkf_pkg::ST_F_ITEM:
            state_in = (i_ff == n_w) ? gmkf_pkg::ST_DONE : gmkf_pkg::ST_F_ORD;
         gmkf_pkg::ST_F_ORD:   state_in = gmkf_pkg::ST_F_RES;
         gmkf_pkg::ST_F_RES:
            state_in = (r_ff == m_w) ? gmkf_pkg::ST_F_PROF : gmkf_pkg::ST_F_CHK;
         gmkf_pkg::ST_F_CHK:   state_in = gmkf_pkg::ST_F_RES;
         gmkf_pkg::ST_F_PROF:  state_in = gmkf_pkg::ST_F_ITEM;
         gmkf_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = gmkf_pkg::ST_IDLE;
            end
         end
         default:    state_in = gmkf_pkg::ST_IDLE;
      endcase
   end

   // Memory addresses and write enables.
   always_comb begin
      req_tready = (state_ff == gmkf_pkg::ST_IDLE);
      cons_we_w  = 1'b0;
      prof_we_w  = 1'b0;
      use_we_w   = 1'b0;
      ord_we_w   = 1'b0;
      cons_wa_w  = CAW'(CAW'(req_item_w) * CAW'(MAX_RESOURCES) + CAW'(req_res_w));
      prof_wa_w  = IW'(req_item_w);
      cons_ra_w  = CAW'(CAW'(i_ff[IW-1:0]) * CAW'(MAX_RESOURCES) + CAW'(r_ff));
      prof_ra_w  = i_ff[IW-1:0];
      use_ra_w   = i_ff[IW-1:0];
      ord_ra_w   = i_ff[IW-1:0];
      unique case (state_ff)
         gmkf_pkg::ST_IDLE: begin
            if (req_fire_w && 32'(req_item_w) < MAX_ITEMS) begin
               cons_we_w = (act_w == gmkf_pkg::ACT_CONSUMPTION) &&
                           (32'(req_res_w) < MAX_RESOURCES);
               prof_we_w = (act_w == gmkf_pkg::ACT_PROFIT);
            end
         end
         gmkf_pkg::ST_U_RES: begin
            use_we_w = (r_ff == m_w);
         end
         gmkf_pkg::ST_R_READJ: begin
            ord_we_w  = (j_ff == n_w);
            prof_ra_w = j_ff[IW-1:0];
            use_ra_w  = j_ff[IW-1:0];
         end
         gmkf_pkg::ST_F_RES: begin
            cons_ra_w = CAW'(CAW'(it_ff) * CAW'(MAX_RESOURCES) + CAW'(r_ff));
            prof_ra_w = it_ff;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gmkf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         items_ff     <= '0;
         res_ff       <= 3'd1;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            unique case (gmkf_pkg::csr_reg_type'(csr_index))
               gmkf_pkg::REG_ITEMS_IN_USE:     items_ff <= csr_wdata;
               gmkf_pkg::REG_RESOURCES_IN_USE: res_ff   <= csr_wdata[2:0];
               default: begin
               end
            endcase
         end
         if (state_ff == gmkf_pkg::ST_DONE && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a_w) * 64'(mul_b_w);
      case (state_ff)
         gmkf_pkg::ST_IDLE: begin
            i_ff <= '0;
            for (int g = 0; g < MAX_RESOURCES; g++) begin
               if (req_fire_w && act_w == gmkf_pkg::ACT_CAPACITY && 32'(req_res_w) == g) begin
                  cap_ff[g] <= req_val_w;
               end
            end
         end
         gmkf_pkg::ST_U_ITEM: begin
            r_ff   <= '0;
            sum_ff <= '0;
            if (i_ff == n_w) begin
               i_ff <= '0;
            end
         end
         gmkf_pkg::ST_U_RES: begin
            if (r_ff == m_w) begin
               i_ff <= i_ff + CW'(1);
            end else if (cap_sel_w == '0) begin
               r_ff <= r_ff + RCW'(1);
            end
         end
         gmkf_pkg::ST_U_WAIT: begin
            dvd_ff  <= QW'({cons_rd_w, {USAGE_FRACTION_BITS{1'b0}}});
            rem_ff  <= '0;
            dcnt_ff <= DCW'(QW);
         end
         gmkf_pkg::ST_U_DIV: begin
            rem_ff  <= ge_w ? 32'(trial_w - {1'b0, cap_sel_w}) : trial_w[31:0];
            dvd_ff  <= quot_w;
            dcnt_ff <= dcnt_ff - DCW'(1);
            if (dcnt_ff == DCW'(1)) begin
               sum_ff <= sum_ff + SW'(quot_w);
               r_ff   <= r_ff + RCW'(1);
            end
         end
         gmkf_pkg::ST_R_ITEM: begin
            if (i_ff == n_w) begin
               // Entering the fill walk: clear the running totals.
               i_ff    <= '0;
               mask_ff <= '0;
               psum_ff <= '0;
               for (int g = 0; g < MAX_RESOURCES; g++) begin
                  tot_ff[g] <= '0;
               end
            end
         end
         gmkf_pkg::ST_R_LOADI: begin
            pi_ff  <= prof_rd_w;
            ui_ff  <= use_rd_w;
            j_ff   <= '0;
            cnt_ff <= '0;
         end
         gmkf_pkg::ST_R_READJ: begin
            if (j_ff == n_w) begin
               i_ff <= i_ff + CW'(1);
            end
         end
         gmkf_pkg::ST_R_CAPJ: begin
            pj_ff <= prof_rd_w;
            uj_ff <= use_rd_w;
         end
         gmkf_pkg::ST_R_MAH: begin
            acc_a_ff <= PW'(prod_ff);
         end
         gmkf_pkg::ST_R_MBL: begin
            acc_a_ff <= acc_a_ff + PW'({prod_ff, 32'b0});
         end
         gmkf_pkg::ST_R_MBH: begin
            acc_b_ff <= PW'(prod_ff);
         end
         gmkf_pkg::ST_R_CMP: begin
            if (before_w) begin
               cnt_ff <= cnt_ff + IW'(1);
            end
            j_ff <= j_ff + CW'(1);
         end
         gmkf_pkg::ST_F_ORD: begin
            it_ff  <= ord_rd_w;
            r_ff   <= '0;
            fit_ff <= 1'b1;
         end
         gmkf_pkg::ST_F_CHK: begin
            buf_ff[r_ff[RIW-1:0]] <= cons_rd_w;
            if (over_w) begin
               fit_ff <= 1'b0;
            end
            r_ff <= r_ff + RCW'(1);
         end
         gmkf_pkg::ST_F_PROF: begin
            if (fit_ff) begin
               mask_ff[it_ff] <= 1'b1;
               psum_ff <= psum_ff + gmkf_pkg::PROFIT_W'(prof_rd_w);
               for (int g = 0; g < MAX_RESOURCES; g++) begin
                  if (RCW'(g) < m_w) begin
                     tot_ff[g] <= tot_ff[g] + buf_ff[g];
                  end
               end
            end
            i_ff <= i_ff + CW'(1);
         end
         gmkf_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_ff <= {{PAD{1'b0}}, psum_ff, gmkf_pkg::MASK_W'(mask_ff)};
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
